// ----- rtl/core/ffhba_pkg.sv -----
// Package: sizes, codes, state type and scan result type of the header bitmap allocator.
`timescale 1ns / 1ps

package ffhba_pkg;

  // Buffer geometry
  localparam int BUFFER_BYTES = 4096;
  localparam int ADDR_W       = $clog2(BUFFER_BYTES);
  // Cursor can run past the end by one skipped block
  localparam int CUR_W        = ADDR_W + 1;
  localparam int SUM_W        = CUR_W + 1;

  // Item field widths
  localparam int FUNC_W       = 1;
  localparam int REQ_W        = 12;
  localparam int IN_ADDR_W    = 13;
  localparam int OUT_ADDR_W   = 13;
  localparam int STATUS_W     = 2;
  localparam int MATCH_W      = ((CUR_W > IN_ADDR_W) ? CUR_W : IN_ADDR_W) + 1;

  // Header memory entry: header bit over block length
  localparam int LEN_W        = 8;
  localparam int ENTRY_W      = LEN_W + 1;
  localparam int MAX_BLOCK    = 255;
  localparam logic [LEN_W-1:0] LEN_MASK = 8'hFF;

  typedef logic [STATUS_W-1:0] status_t;

  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 1'b1;

  localparam status_t STATUS_OK            = 2'd0;
  localparam status_t STATUS_NO_SPACE      = 2'd1;
  localparam status_t STATUS_TOO_LARGE     = 2'd2;
  localparam status_t STATUS_NOT_ALLOCATED = 2'd3;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Outcome of evaluating one header position
  typedef struct packed {
    logic                  done;
    status_t               status;
    logic [OUT_ADDR_W-1:0] addr;
    logic [CUR_W-1:0]      cur;
    logic                  run;
    logic [ADDR_W-1:0]     start;
    logic                  we;
    logic [ADDR_W-1:0]     waddr;
    logic [ENTRY_W-1:0]    wdata;
  } scan_t;

endpackage

// ----- rtl/core/ffhba_in_if.sv -----
// Interface: request channel of the allocator (valid, ready, request fields).
`timescale 1ns / 1ps

interface ffhba_in_if;
  logic                                valid;
  logic                                ready;
  logic [ffhba_pkg::FUNC_W-1:0]        func;
  logic [ffhba_pkg::REQ_W-1:0]         request_size;
  logic [ffhba_pkg::IN_ADDR_W-1:0]     free_address;

  modport source (output valid, output func, output request_size, output free_address,
                  input ready);
  modport sink   (input valid, input func, input request_size, input free_address,
                  output ready);
endinterface

// ----- rtl/core/ffhba_out_if.sv -----
// Interface: result channel of the allocator (valid, ready, result fields).
`timescale 1ns / 1ps

interface ffhba_out_if;
  logic                                valid;
  logic                                ready;
  logic [ffhba_pkg::OUT_ADDR_W-1:0]    block_address;
  ffhba_pkg::status_t                  status;

  modport source (output valid, output block_address, output status, input ready);
  modport sink   (input valid, input block_address, input status, output ready);
endinterface

// ----- rtl/core/ffhba_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module ffhba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/first_fit_header_bitmap_allocator_top.sv -----
// Top level: first-fit allocator walking a header/length memory one position per cycle.
`timescale 1ns / 1ps

// Channel   Dir  Handshake        Payload
// in_ch     in   valid / ready    func, request_size, free_address
// out_ch    out  valid / ready    block_address, status
//
// After reset a clearing pass writes every header entry, with in_ch.ready low. An item
// is then walked one header position at a time: the walk visits one memory entry per
// cycle through the single read port. An oversized request skips the walk and goes
// straight to its result. The result sits in an output register; the next item is
// taken while it waits.
module first_fit_header_bitmap_allocator_top (
  input  logic                   clk,
  input  logic                   rst_n,
  ffhba_in_if.sink               in_ch,
  ffhba_out_if.source            out_ch
);

  // Control state
  ffhba_pkg::state_t                  state_r, state_nxt;
  logic [ffhba_pkg::ADDR_W-1:0]       clr_cnt_r, clr_cnt_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic                               run_r, run_nxt;

  // Item and walk registers
  logic [ffhba_pkg::FUNC_W-1:0]       func_r, func_nxt;
  logic [ffhba_pkg::LEN_W-1:0]        size_r, size_nxt;
  logic [ffhba_pkg::IN_ADDR_W-1:0]    addr_r, addr_nxt;
  logic [ffhba_pkg::CUR_W-1:0]        cur_r, cur_nxt;
  logic [ffhba_pkg::ADDR_W-1:0]       start_r, start_nxt;
  logic [ffhba_pkg::OUT_ADDR_W-1:0]   res_addr_r, res_addr_nxt;
  ffhba_pkg::status_t                 res_status_r, res_status_nxt;
  logic [ffhba_pkg::OUT_ADDR_W-1:0]   out_addr_r, out_addr_nxt;
  ffhba_pkg::status_t                 out_status_r, out_status_nxt;

  // FSM outputs
  logic                               in_ready;
  logic                               out_load;
  logic                               clr_last;
  logic                               too_large;

  // Memory ports
  logic                               ram_we;
  logic [ffhba_pkg::ADDR_W-1:0]       ram_waddr;
  logic [ffhba_pkg::ENTRY_W-1:0]      ram_wdata;
  logic [ffhba_pkg::ADDR_W-1:0]       ram_raddr;
  logic [ffhba_pkg::ENTRY_W-1:0]      ram_rdata;

  // Scan evaluation
  ffhba_pkg::scan_t                   ev;
  logic                               hdr;
  logic [ffhba_pkg::LEN_W-1:0]        len;
  logic [ffhba_pkg::SUM_W-1:0]        cur_plus_size;
  logic [ffhba_pkg::CUR_W-1:0]        cur_jump;
  logic [ffhba_pkg::CUR_W-1:0]        cur_inc;
  logic [ffhba_pkg::CUR_W-1:0]        run_end;
  logic                               free_match;

  // Header and length memory
  ffhba_ram #(
    .WIDTH (ffhba_pkg::ENTRY_W),
    .DEPTH (ffhba_pkg::BUFFER_BYTES)
  ) u_hdr_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign hdr = ram_rdata[ffhba_pkg::ENTRY_W-1];
  assign len = ram_rdata[ffhba_pkg::LEN_W-1:0];

  assign clr_last  = (clr_cnt_r == ffhba_pkg::ADDR_W'(ffhba_pkg::BUFFER_BYTES - 1));
  assign too_large = (in_ch.func == ffhba_pkg::FUNC_ALLOC) &&
                     (in_ch.request_size > ffhba_pkg::REQ_W'(ffhba_pkg::MAX_BLOCK));

  // Position arithmetic for the entry whose data is on the read port
  assign cur_plus_size = {1'b0, cur_r} + ffhba_pkg::SUM_W'(size_r);
  assign cur_jump      = cur_r + ffhba_pkg::CUR_W'(len) + ffhba_pkg::CUR_W'(1);
  assign cur_inc       = cur_r + ffhba_pkg::CUR_W'(1);
  assign run_end       = ffhba_pkg::CUR_W'(start_r) + ffhba_pkg::CUR_W'(size_r);
  assign free_match    = (ffhba_pkg::MATCH_W'(cur_r) + ffhba_pkg::MATCH_W'(1)) ==
                         ffhba_pkg::MATCH_W'(addr_r);

  // Evaluate one header position; a set bit inside an open run ends the run
  // and is walked as a header, which is where single steps would land anyway
  always_comb begin
    ev        = '0;
    ev.cur    = cur_inc;
    ev.run    = run_r;
    ev.start  = start_r;
    ev.status = ffhba_pkg::STATUS_OK;
    if (func_r == ffhba_pkg::FUNC_ALLOC) begin
      if (!run_r || hdr) begin
        ev.run = 1'b0;
        if (cur_plus_size >= ffhba_pkg::SUM_W'(ffhba_pkg::BUFFER_BYTES)) begin
          ev.done   = 1'b1;
          ev.status = ffhba_pkg::STATUS_NO_SPACE;
        end else if (hdr) begin
          ev.cur = cur_jump;
        end else if (size_r == '0) begin
          // zero-size block occupies its header position only
          ev.done  = 1'b1;
          ev.addr  = ffhba_pkg::OUT_ADDR_W'(cur_inc);
          ev.we    = 1'b1;
          ev.waddr = cur_r[ffhba_pkg::ADDR_W-1:0];
          ev.wdata = {1'b1, size_r & ffhba_pkg::LEN_MASK};
        end else begin
          ev.run   = 1'b1;
          ev.start = cur_r[ffhba_pkg::ADDR_W-1:0];
        end
      end else if (cur_r == run_end) begin
        ev.done  = 1'b1;
        ev.addr  = ffhba_pkg::OUT_ADDR_W'(ffhba_pkg::CUR_W'(start_r) + ffhba_pkg::CUR_W'(1));
        ev.we    = 1'b1;
        ev.waddr = start_r;
        ev.wdata = {1'b1, size_r & ffhba_pkg::LEN_MASK};
        ev.run   = 1'b0;
      end
    end else begin
      ev.run = 1'b0;
      if (cur_r >= ffhba_pkg::CUR_W'(ffhba_pkg::BUFFER_BYTES)) begin
        ev.done   = 1'b1;
        ev.status = ffhba_pkg::STATUS_NOT_ALLOCATED;
      end else if (hdr) begin
        if (free_match) begin
          ev.done  = 1'b1;
          ev.we    = 1'b1;
          ev.waddr = cur_r[ffhba_pkg::ADDR_W-1:0];
          ev.wdata = '0;
        end else begin
          ev.cur = cur_jump;
        end
      end
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ffhba_pkg::ST_CLEAR: begin
        if (clr_last) state_nxt = ffhba_pkg::ST_IDLE;
      end
      ffhba_pkg::ST_IDLE: begin
        if (in_ch.valid) state_nxt = too_large ? ffhba_pkg::ST_DONE : ffhba_pkg::ST_SCAN;
      end
      ffhba_pkg::ST_SCAN: begin
        if (ev.done) state_nxt = ffhba_pkg::ST_DONE;
      end
      ffhba_pkg::ST_DONE: begin
        if (!out_valid_r || out_ch.ready) state_nxt = ffhba_pkg::ST_IDLE;
      end
      default: state_nxt = ffhba_pkg::ST_CLEAR;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_ready  = 1'b0;
    out_load  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = clr_cnt_r;
    ram_wdata = '0;
    case (state_r)
      ffhba_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ffhba_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      ffhba_pkg::ST_SCAN: begin
        ram_we    = ev.we;
        ram_waddr = ev.waddr;
        ram_wdata = ev.wdata;
      end
      ffhba_pkg::ST_DONE: begin
        out_load = !out_valid_r || out_ch.ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Datapath next values
  always_comb begin
    clr_cnt_nxt    = clr_cnt_r;
    func_nxt       = func_r;
    size_nxt       = size_r;
    addr_nxt       = addr_r;
    cur_nxt        = cur_r;
    run_nxt        = run_r;
    start_nxt      = start_r;
    res_addr_nxt   = res_addr_r;
    res_status_nxt = res_status_r;
    out_addr_nxt   = out_addr_r;
    out_status_nxt = out_status_r;

    if (state_r == ffhba_pkg::ST_CLEAR) begin
      clr_cnt_nxt = clr_cnt_r + ffhba_pkg::ADDR_W'(1);
    end

    // Accept an item; the walk starts at position 0
    if (in_ready && in_ch.valid) begin
      func_nxt       = in_ch.func;
      size_nxt       = in_ch.request_size[ffhba_pkg::LEN_W-1:0];
      addr_nxt       = in_ch.free_address;
      cur_nxt        = '0;
      run_nxt        = 1'b0;
      res_addr_nxt   = '0;
      res_status_nxt = ffhba_pkg::STATUS_TOO_LARGE;
    end

    if (state_r == ffhba_pkg::ST_SCAN) begin
      cur_nxt   = ev.cur;
      run_nxt   = ev.run;
      start_nxt = ev.start;
      if (ev.done) begin
        res_addr_nxt   = ev.addr;
        res_status_nxt = ev.status;
      end
    end

    if (out_load) begin
      out_addr_nxt   = res_addr_r;
      out_status_nxt = res_status_r;
    end
  end

  // Read the entry for the next cursor every cycle
  assign ram_raddr     = cur_nxt[ffhba_pkg::ADDR_W-1:0];
  assign out_valid_nxt = out_load || (out_valid_r && !out_ch.ready);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ffhba_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      run_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      run_r       <= run_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    size_r       <= size_nxt;
    addr_r       <= addr_nxt;
    cur_r        <= cur_nxt;
    start_r      <= start_nxt;
    res_addr_r   <= res_addr_nxt;
    res_status_r <= res_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
  end

  assign in_ch.ready          = in_ready;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.block_address = out_addr_r;
  assign out_ch.status        = out_status_r;

`ifndef SYNTH
  // Memory writes during a walk only at its final position
  a_write_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ffhba_pkg::ST_SCAN && ram_we) |-> ev.done)
    else $error("header write before walk end");

  // A result appears only out of the done state
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ffhba_pkg::ST_DONE))
    else $error("result without finished walk");

  // No item taken during the clearing pass
  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ffhba_pkg::ST_CLEAR) |-> !in_ch.ready)
    else $error("ready during clearing pass");

  // An open run never leaves the buffer
  a_run_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ffhba_pkg::ST_SCAN && run_r) |->
      (cur_r < ffhba_pkg::CUR_W'(ffhba_pkg::BUFFER_BYTES)))
    else $error("run check past buffer end");

  // Failed results carry address zero; free results set it to zero too
  a_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ffhba_pkg::STATUS_OK) |-> (out_addr_r == '0))
    else $error("nonzero address on failed item");
`endif

endmodule

// ----- tb/first_fit_header_bitmap_allocator_top_tb.sv -----
// Testbench: first-fit header bitmap allocator checked against a shadow heap scoreboard.
`timescale 1ns / 1ps

module first_fit_header_bitmap_allocator_top_tb;
  import ffhba_pkg::*;

  localparam int RANDOM_ITEMS   = 1145;
  localparam int WATCHDOG_LIMIT = 50000;
  localparam int TAIL_CYCLES    = BUFFER_BYTES + 16;
  localparam int MAX_REPORTS    = 10;

  // One result item as the block should return it
  typedef struct packed {
    logic [OUT_ADDR_W-1:0] block_address;
    status_t               status;
  } reply_t;

  // Shadow heap: header bits, block lengths and the replies still owed
  class heap_scoreboard;
    bit                hdr_set [BUFFER_BYTES];
    logic [LEN_W-1:0]  blk_len [BUFFER_BYTES];
    reply_t            pending_replies [$];
    int unsigned       live_addrs [$];
    int unsigned       bytes_in_use;
    int unsigned       mismatches;

    function new();
      for (int i = 0; i < BUFFER_BYTES; i++) begin
        hdr_set[i] = 1'b0;
        blk_len[i] = '0;
      end
      bytes_in_use = 0;
      mismatches   = 0;
    endfunction

    // True when count positions from start are inside the buffer and unmarked
    function bit run_is_free(int unsigned start, int unsigned count);
      for (int unsigned k = 0; k < count; k++) begin
        if (start + k >= BUFFER_BYTES || hdr_set[start + k]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function reply_t predict_alloc(int unsigned size);
      reply_t      r;
      int unsigned pos;
      r.block_address = '0;
      pos = 0;
      if (size > MAX_BLOCK) begin
        r.status = STATUS_TOO_LARGE;
        return r;
      end
      // First fit: hop over blocks, creep over free positions
      while (pos + size < BUFFER_BYTES) begin
        if (hdr_set[pos]) begin
          pos += blk_len[pos] + 1;
        end else if (run_is_free(pos, size + 1)) begin
          hdr_set[pos] = 1'b1;
          blk_len[pos] = size[LEN_W-1:0];
          r.block_address = OUT_ADDR_W'(pos + 1);
          r.status = STATUS_OK;
          live_addrs.push_back(pos + 1);
          bytes_in_use += size + 1;
          return r;
        end else begin
          pos += 1;
        end
      end
      r.status = STATUS_NO_SPACE;
      return r;
    endfunction

    function reply_t predict_free(int unsigned addr);
      reply_t      r;
      int unsigned pos;
      r.block_address = '0;
      pos = 0;
      while (pos < BUFFER_BYTES) begin
        if (hdr_set[pos]) begin
          if (pos + 1 == addr) begin
            bytes_in_use -= blk_len[pos] + 1;
            hdr_set[pos] = 1'b0;
            blk_len[pos] = '0;
            for (int i = 0; i < live_addrs.size(); i++) begin
              if (live_addrs[i] == addr) begin
                live_addrs.delete(i);
                break;
              end
            end
            r.status = STATUS_OK;
            return r;
          end
          pos += blk_len[pos] + 1;
        end else begin
          pos += 1;
        end
      end
      r.status = STATUS_NOT_ALLOCATED;
      return r;
    endfunction

    // Accepted request item: update the shadow heap and queue its reply
    function void note_request(logic [FUNC_W-1:0] func, logic [REQ_W-1:0] size,
                               logic [IN_ADDR_W-1:0] addr);
      if (func == FUNC_ALLOC) pending_replies.push_back(predict_alloc(size));
      else pending_replies.push_back(predict_free(addr));
    endfunction

    // Accepted result item: compare with the oldest owed reply
    function void check_result(logic [OUT_ADDR_W-1:0] block_address, status_t status);
      reply_t want;
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: block_address %0d status %0d", block_address, status);
        return;
      end
      want = pending_replies.pop_front();
      if (block_address !== want.block_address || status !== want.status) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("mismatch: block_address exp %0d got %0d, status exp %0d got %0d",
                   want.block_address, block_address, want.status, status);
      end
    endfunction

    function int outstanding();
      return pending_replies.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int unsigned idle_cycles = 0;
  heap_scoreboard sb;

  ffhba_in_if  in_ch ();
  ffhba_out_if out_ch ();

  first_fit_header_bitmap_allocator_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.block_address, out_ch.status);
  end

  // Watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: switches between always-ready, patterned and random stall modes
  initial begin
    int unsigned stall_mode;
    int unsigned mode_left;
    logic [7:0]  stall_pat;
    logic [2:0]  phase;
    out_ch.ready = 1'b0;
    mode_left = 0;
    stall_mode = 0;
    stall_pat = 8'hFF;
    phase = '0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left  = $urandom_range(50, 400);
        stall_pat  = 8'($urandom) | 8'h01;
      end
      mode_left--;
      case (stall_mode)
        0: begin
          out_ch.ready = 1'b1;
        end
        1: begin
          out_ch.ready = stall_pat[phase];
          phase++;
        end
        default: begin
          out_ch.ready = ($urandom_range(0, 3) != 0);
        end
      endcase
    end
  end

  // Present one request item and hold it until accepted
  task automatic send_item(input logic [FUNC_W-1:0] func, input logic [REQ_W-1:0] size,
                           input logic [IN_ADDR_W-1:0] addr);
    in_ch.valid        = 1'b1;
    in_ch.func         = func;
    in_ch.request_size = size;
    in_ch.free_address = addr;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(func, size, addr);
    @(negedge clk);
  endtask

  task automatic hold_off(input int unsigned cycles);
    in_ch.valid = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic pause_until_drained();
    in_ch.valid = 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
  endtask

  // Edge cases: zero size, oversize, filling to the last position, first-fit reuse
  task automatic run_directed();
    send_item(FUNC_ALLOC, 12'd0, 13'd8191);
    send_item(FUNC_FREE, 12'd4095, 13'd1);
    send_item(FUNC_FREE, 12'd0, 13'd0);
    send_item(FUNC_ALLOC, 12'd4095, 13'd0);
    send_item(FUNC_ALLOC, 12'd256, 13'd0);
    for (int i = 0; i < 15; i++) send_item(FUNC_ALLOC, 12'd255, 13'($urandom_range(0, 8191)));
    send_item(FUNC_ALLOC, 12'd254, 13'd0);
    // last position, address at the top of the range
    send_item(FUNC_ALLOC, 12'd0, 13'd0);
    send_item(FUNC_ALLOC, 12'd0, 13'd0);
    send_item(FUNC_FREE, 12'd0, 13'd4096);
    send_item(FUNC_FREE, 12'd0, 13'd257);
    send_item(FUNC_ALLOC, 12'd10, 13'd0);
  endtask

  task automatic send_random_item(input bit filling);
    int unsigned r;
    int unsigned size;
    bit          do_free;
    r = $urandom_range(0, 4095);
    if (sb.live_addrs.size() == 0) do_free = 1'b0;
    else if (filling) do_free = (r < 400);
    else do_free = (r < sb.bytes_in_use + 400);

    if (do_free) begin
      // mostly live blocks, some stray addresses
      if ($urandom_range(0, 99) < 90)
        send_item(FUNC_FREE, 12'($urandom_range(0, 4095)),
                  13'(sb.live_addrs[$urandom_range(0, sb.live_addrs.size() - 1)]));
      else
        send_item(FUNC_FREE, 12'($urandom_range(0, 4095)), 13'($urandom_range(0, 8191)));
    end else begin
      r = $urandom_range(0, 99);
      if (r < 3) size = $urandom_range(256, 4095);
      else if (r < 55) size = $urandom_range(0, 15);
      else if (r < 85) size = $urandom_range(16, 63);
      else size = $urandom_range(64, 255);
      send_item(FUNC_ALLOC, 12'(size), 13'($urandom_range(0, 8191)));
    end
  endtask

  // Stimulus and end of run
  initial begin
    int unsigned burst_left;
    sb = new();
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.func         = FUNC_ALLOC;
    in_ch.request_size = '0;
    in_ch.free_address = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    run_directed();
    pause_until_drained();

    burst_left = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) pause_until_drained();
      if (burst_left == 0) begin
        if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 8));
        burst_left = $urandom_range(1, 12);
      end
      // alternate churn with stretches that drive the heap to full
      send_random_item((n / 150) % 3 == 1);
      burst_left--;
    end
    in_ch.valid = 1'b0;

    while (sb.outstanding() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
